/* hdl/bitvector_dataflow_solver_defines.svh */
// ----------------------------------------------------------------------------
// bitvector dataflow solver assertion macros
// shared assertion helpers, removable with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef BITVECTOR_DATAFLOW_SOLVER_DEFINES_SVH
`define BITVECTOR_DATAFLOW_SOLVER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define BDS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define BDS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BDS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BDS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* hdl/bds_pkg.sv */
// ----------------------------------------------------------------------------
// bds_pkg
// types and codes for the bit-vector dataflow solver
// ----------------------------------------------------------------------------
`default_nettype none
package bds_pkg;
    localparam int SLOT_LIMIT = 256;
    localparam int VAR_MAX    = 64;

    typedef enum logic [1:0] {
        KIND_LOAD = 2'd0,
        KIND_EDGE = 2'd1,
        KIND_SOLVE = 2'd2,
        KIND_READ = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        MODE_REACH = 2'd0,
        MODE_AVAIL = 2'd1,
        MODE_LIVE  = 2'd2,
        MODE_BUSY  = 2'd3
    } mode_t;

    typedef enum logic {
        CFG_MODE   = 1'b0,
        CFG_BLOCKS = 1'b1
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INIT,
        ST_PASS,
        ST_BLK_RD,
        ST_ITER,
        ST_EDGE_WAIT,
        ST_EDGE_ACC,
        ST_BLK_WR,
        ST_RD_WAIT,
        ST_OUT
    } state_t;
endpackage
`default_nettype wire

/* hdl/bitvector_dataflow_solver.sv */
// ----------------------------------------------------------------------------
// bitvector_dataflow_solver: load/edge go from ST_IDLE to ST_OUT, a read via ST_RD_WAIT
// solve: ST_INIT per block, then per pass ST_PASS, per block ST_BLK_RD, ST_ITER, ST_BLK_WR,
//   per scanned edge ST_EDGE_WAIT, ST_EDGE_ACC; backward lists end at first hit; then ST_OUT
// one item at a time: a new input is taken only after the result has been transferred;
//   reset runs a clearing pass over every slot's sets and counts, input held off meanwhile
// ----------------------------------------------------------------------------
`default_nettype none
`include "bitvector_dataflow_solver_defines.svh"
module bitvector_dataflow_solver #(
    parameter int MAX_BLOCKS = 256,
    parameter int MAX_PREDS  = 64,
    parameter int VARS       = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  kind,
    input  wire logic [7:0]  block,
    input  wire logic [7:0]  pred_block,
    input  wire logic [63:0] gen_bits,
    input  wire logic [63:0] kill_bits,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             status,
    output logic [63:0]      in_bits,
    output logic [63:0]      out_bits,
    output logic [15:0]      pass_count,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [63:0] cfg_data
);
    import bds_pkg::*;

    // slot count and index widths
    localparam int NSLOT = (MAX_BLOCKS < SLOT_LIMIT) ? MAX_BLOCKS : SLOT_LIMIT;
    localparam int BW    = (NSLOT > 1) ? $clog2(NSLOT) : 1;
    localparam int NW    = $clog2(NSLOT + 1);
    localparam int PW    = (MAX_PREDS > 1) ? $clog2(MAX_PREDS) : 1;
    localparam int CW    = $clog2(MAX_PREDS + 1);
    localparam int EW    = BW + PW;
    localparam logic [63:0] SET_MASK = {64{1'b1}} >> (VAR_MAX - VARS);

    // configuration
    logic [1:0] mode_reg;
    logic [8:0] bcount_reg;
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_REACH;
            bcount_reg <= 9'd1;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_MODE)
                mode_reg <= cfg_data[1:0];
            else
                bcount_reg <= cfg_data[8:0];
        end
    end

    // blocks in use, clamped
    logic [NW-1:0] n_use;
    always_comb
    begin
        if (bcount_reg == 9'd0)
            n_use = NW'(1);
        else if ({23'd0, bcount_reg} > 32'(NSLOT))
            n_use = NW'(NSLOT);
        else
            n_use = NW'(bcount_reg);
    end
    wire inter    = (mode_reg == MODE_AVAIL) || (mode_reg == MODE_BUSY);
    wire backward = mode_reg[1];

    // memories: per-block sets, edge list and predecessor counts
    logic [63:0]  gen_mem  [NSLOT];
    logic [63:0]  kill_mem [NSLOT];
    logic [63:0]  in_mem   [NSLOT];
    logic [63:0]  out_mem  [NSLOT];
    logic [BW-1:0] edge_mem [NSLOT << PW];
    logic [CW-1:0] pcnt_mem [NSLOT];

    // state
    state_t state_reg, state_next;
    logic [1:0]   kind_reg;
    logic [7:0]   blk_reg, src_reg;
    logic [63:0]  gen_in_reg, kill_in_reg;
    logic [NW-1:0] k_reg, k_next;        // block step within pass, or clearing address
    logic [BW-1:0] cur_reg, cur_next;    // block being updated
    logic [NW-1:0] s_reg, s_next;        // scanned block (backward)
    logic [CW-1:0] p_reg, p_next;        // edge slot scanned
    logic [63:0]  meet_reg, meet_next;
    logic         any_reg, any_next;
    logic         chg_reg, chg_next;
    logic [15:0]  pass_reg, pass_next;

    // shared read port results, registered
    logic [63:0] gen_rd_reg, kill_rd_reg, in_rd_reg, out_rd_reg, nb_rd_reg;
    logic [BW-1:0] edge_rd_reg;
    logic [CW-1:0] pcnt_blk_rd_reg, scan_rd_reg;

    // output register
    logic        ov_reg;
    logic        st_o_reg;
    logic [63:0] in_o_reg, out_o_reg;
    logic [15:0] pc_o_reg;

    assign in_ready   = (state_reg == ST_IDLE) && !ov_reg;
    assign out_valid  = ov_reg;
    assign status     = st_o_reg;
    assign in_bits    = in_o_reg;
    assign out_bits   = out_o_reg;
    assign pass_count = pc_o_reg;

    wire in_xfer = in_valid && in_ready;

    // edge memory read address: current block's list, or scanned block's list
    logic [BW-1:0] ed_blk;
    logic [EW-1:0] ed_addr;
    wire  [BW-1:0] s_idx = s_reg[BW-1:0];
    wire  [PW-1:0] p_idx = p_reg[PW-1:0];
    assign ed_blk  = backward ? s_idx : cur_reg;
    assign ed_addr = {ed_blk, p_idx};

    wire cur_ok   = 32'(blk_reg) < 32'(NSLOT);
    wire src_ok   = 32'(src_reg) < 32'(NSLOT);
    wire [BW-1:0] blk_idx = blk_reg[BW-1:0];
    wire [BW-1:0] src_idx = src_reg[BW-1:0];
    wire edge_ok  = cur_ok && src_ok && (32'(pcnt_blk_rd_reg) < 32'(MAX_PREDS));

    // scan bound for the block whose list is scanned, read ahead with the next indices
    wire [CW-1:0] scan_cnt = scan_rd_reg;
    wire          edge_hit = backward ? (edge_rd_reg == cur_reg)
                                      : (32'(edge_rd_reg) < 32'(n_use));
    wire [63:0]   nb_val   = nb_rd_reg;
    wire [63:0]   meet_fin = ((mode_reg == MODE_AVAIL && cur_reg == '0) ? 64'd0 : meet_reg)
                             & SET_MASK;
    wire [63:0]   res_fin  = (gen_rd_reg | (meet_fin & ~kill_rd_reg)) & SET_MASK;
    wire [63:0]   old_a    = backward ? out_rd_reg : in_rd_reg;
    wire [63:0]   old_b    = backward ? in_rd_reg : out_rd_reg;
    wire [63:0]   init_val = inter ? SET_MASK : 64'd0;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        cur_next   = cur_reg;
        s_next     = s_reg;
        p_next     = p_reg;
        meet_next  = meet_reg;
        any_next   = any_reg;
        chg_next   = chg_reg;
        pass_next  = pass_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                // zero every set and count slot once after reset
                k_next = k_reg + NW'(1);
                if (k_reg + NW'(1) == NW'(NSLOT))
                begin
                    k_next     = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    case (kind_t'(kind))
                        KIND_SOLVE:
                        begin
                            state_next = ST_INIT;
                            k_next     = '0;
                            pass_next  = '0;
                        end
                        KIND_READ: state_next = ST_RD_WAIT;
                        default:   state_next = ST_OUT;
                    endcase
                end
            end
            ST_INIT:
            begin
                k_next = k_reg + NW'(1);
                if (k_reg + NW'(1) == n_use)
                    state_next = ST_PASS;
            end
            ST_PASS:
            begin
                chg_next  = 1'b0;
                k_next    = '0;
                if (pass_reg != 16'hFFFF)
                    pass_next = pass_reg + 16'd1;
                cur_next  = backward ? BW'(n_use - NW'(1)) : '0;
                state_next = ST_BLK_RD;
            end
            ST_BLK_RD:
            begin
                meet_next  = '0;
                any_next   = 1'b0;
                s_next     = '0;
                p_next     = '0;
                state_next = ST_ITER;
            end
            ST_ITER:
            begin
                // issue the next edge read or finish the block
                if (backward)
                begin
                    if (s_reg == n_use)
                        state_next = ST_BLK_WR;
                    else if (p_reg >= scan_cnt || 32'(p_reg) >= 32'(MAX_PREDS))
                    begin
                        s_next = s_reg + NW'(1);
                        p_next = '0;
                    end
                    else
                        state_next = ST_EDGE_WAIT;
                end
                else
                begin
                    if (p_reg >= scan_cnt || 32'(p_reg) >= 32'(MAX_PREDS))
                        state_next = ST_BLK_WR;
                    else
                        state_next = ST_EDGE_WAIT;
                end
            end
            ST_EDGE_WAIT: state_next = ST_EDGE_ACC;
            ST_EDGE_ACC:
            begin
                // one meet step; backward: a hit means block s succeeds cur
                if (edge_hit && (backward ? !any_reg || 1'b1 : 1'b1))
                begin
                    if (!any_reg)
                        meet_next = nb_val;
                    else
                        meet_next = inter ? (meet_reg & nb_val) : (meet_reg | nb_val);
                    any_next = 1'b1;
                end
                if (backward && edge_hit)
                begin
                    // duplicates add nothing; skip the rest of this list
                    s_next = s_reg + NW'(1);
                    p_next = '0;
                end
                else
                    p_next = p_reg + CW'(1);
                state_next = ST_ITER;
            end
            ST_BLK_WR:
            begin
                if (old_a != meet_fin || old_b != res_fin)
                    chg_next = 1'b1;
                k_next = k_reg + NW'(1);
                cur_next = backward ? cur_reg - BW'(1) : cur_reg + BW'(1);
                if (k_reg + NW'(1) == n_use)
                begin
                    if (old_a != meet_fin || old_b != res_fin || chg_reg)
                        state_next = ST_PASS;
                    else
                        state_next = ST_OUT;
                end
                else
                    state_next = ST_BLK_RD;
            end
            ST_RD_WAIT: state_next = ST_OUT;
            ST_OUT:     state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            k_reg     <= '0;
            cur_reg   <= '0;
            s_reg     <= '0;
            p_reg     <= '0;
            meet_reg  <= '0;
            any_reg   <= 1'b0;
            chg_reg   <= 1'b0;
            pass_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            cur_reg   <= cur_next;
            s_reg     <= s_next;
            p_reg     <= p_next;
            meet_reg  <= meet_next;
            any_reg   <= any_next;
            chg_reg   <= chg_next;
            pass_reg  <= pass_next;
        end
    end

    // captured item
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            kind_reg    <= kind;
            blk_reg     <= block;
            src_reg     <= pred_block;
            gen_in_reg  <= gen_bits;
            kill_in_reg <= kill_bits;
        end
    end

    // neighbour set read: OUT of predecessor forward, IN of block s backward
    wire [BW-1:0] nb_addr = backward ? s_idx : edge_rd_reg;

    // memory reads, registered
    always_ff @(posedge clk)
    begin
        edge_rd_reg     <= edge_mem[ed_addr];
        gen_rd_reg      <= gen_mem[state_reg == ST_RD_WAIT ? blk_idx : cur_reg];
        kill_rd_reg     <= kill_mem[cur_reg];
        in_rd_reg       <= in_mem[state_reg == ST_RD_WAIT ? blk_idx : cur_reg];
        out_rd_reg      <= out_mem[state_reg == ST_RD_WAIT ? blk_idx : cur_reg];
        nb_rd_reg       <= backward ? in_mem[nb_addr] : out_mem[nb_addr];
        // count of the addressed block, taken as the item is transferred
        pcnt_blk_rd_reg <= pcnt_mem[in_xfer ? block[BW-1:0] : blk_idx];
        scan_rd_reg     <= pcnt_mem[backward ? s_next[BW-1:0] : cur_next];
    end

    // memory writes
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLEAR)
        begin
            gen_mem[k_reg[BW-1:0]]  <= '0;
            kill_mem[k_reg[BW-1:0]] <= '0;
            pcnt_mem[k_reg[BW-1:0]] <= '0;
        end
        else
        begin
            if (state_reg == ST_OUT && kind_reg == KIND_LOAD && cur_ok)
            begin
                gen_mem[blk_idx]  <= gen_in_reg & SET_MASK;
                kill_mem[blk_idx] <= kill_in_reg & SET_MASK;
            end
            if (state_reg == ST_OUT && kind_reg == KIND_EDGE && edge_ok)
            begin
                edge_mem[{blk_idx, pcnt_blk_rd_reg[PW-1:0]}] <= src_idx;
                pcnt_mem[blk_idx] <= pcnt_blk_rd_reg + CW'(1);
            end
        end
        if (state_reg == ST_CLEAR)
        begin
            in_mem[k_reg[BW-1:0]]  <= '0;
            out_mem[k_reg[BW-1:0]] <= '0;
        end
        else if (state_reg == ST_INIT)
        begin
            in_mem[k_reg[BW-1:0]]  <= init_val;
            out_mem[k_reg[BW-1:0]] <= init_val;
        end
        else if (state_reg == ST_BLK_WR)
        begin
            in_mem[cur_reg]  <= backward ? res_fin : meet_fin;
            out_mem[cur_reg] <= backward ? meet_fin : res_fin;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (state_reg == ST_OUT)
            ov_reg <= 1'b1;
        else if (out_ready)
            ov_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT)
        begin
            st_o_reg  <= (kind_reg == KIND_EDGE) && !edge_ok;
            pc_o_reg  <= (kind_reg == KIND_SOLVE) ? pass_reg : 16'd0;
            in_o_reg  <= (kind_reg == KIND_READ && cur_ok)
                         ? in_rd_reg & SET_MASK : 64'd0;
            out_o_reg <= (kind_reg == KIND_READ && cur_ok)
                         ? out_rd_reg & SET_MASK : 64'd0;
        end
    end

    // assertions
    `BDS_ASSERT_IMP(a_ready_idle, clk, rst_n, in_ready, state_reg == ST_IDLE)
    `BDS_ASSERT_NXT(a_out_after_done, clk, rst_n, state_reg == ST_OUT, out_valid)
    `BDS_ASSERT_IMP(a_no_accept_busy, clk, rst_n, state_reg != ST_IDLE, !in_ready)
endmodule
`default_nettype wire
